// ===== src/lsbhx_pkg.sv =====
// shared types and constants for the low-bit header extractor
// no dependencies; imported by every module of the block
package lsbhx_pkg;

  // dimension field width fixed by the header format, and the config register index width
  localparam int unsigned DIM_W       = 11;
  localparam int unsigned CFG_INDEX_W = 2;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  // result kinds
  localparam logic [1:0] KIND_EXT  = 2'd0;
  localparam logic [1:0] KIND_PAY  = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;
  localparam logic [1:0] KIND_DONE = 2'd3;

  // error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_HEADER    = 3'd1;
  localparam logic [2:0] ERR_SEPARATOR = 3'd2;
  localparam logic [2:0] ERR_SIZE      = 3'd3;
  localparam logic [2:0] ERR_EXT_LONG  = 3'd4;
  localparam logic [2:0] ERR_TRUNCATED = 3'd5;

  // stream characters
  localparam logic [7:0] SEP_CHAR     = 8'h78;
  localparam logic [7:0] NEWLINE_CHAR = 8'h0a;

  // one input word
  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       first_byte;
    logic       final_byte;
  } item_t;

  // one result word
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  byte_value;
    logic [2:0]  error_code;
    logic [31:0] payload_bits;
    logic        run_end;
  } result_t;

  // results caused by one input word, head goes out first
  typedef struct packed {
    logic [1:0] cnt;
    result_t    head;
    result_t    tail;
  } res_pair_t;

endpackage

// ===== src/lsb_stego_header_extractor.sv =====
// Low-bit header extractor, top level.
// Input channel: one color byte per word (valid/stall); first_byte restarts the parse,
// final_byte marks the end of the image. Output channel: result words (valid/stall),
// extension bytes, payload bytes, then a done or error word; run_end marks the last
// result word caused by one input word. Each input word gives zero, one or two results.
// Config port: valid/ready writes of image_width (index 0) and image_height (index 1),
// always ready; write only while no word is in flight.
// An accepted word is held in the input register until its results have room;
// it is then parsed and its results are loaded into the result register.
// Throughput: one input word per cycle while out_stall_i is low; a word with two
// results holds back the next word, as the result register drains one word per cycle.
// Stall: a stalled output holds its word; the input keeps taking words until the input
// register and its skid entry fill, then raises in_stall_o, which comes from a flop.
// Reset: the parser goes idle and ignores words until one with first_byte set; both
// config registers clear to zero; buffers empty.
// depends on lsbhx_pkg, lsbhx_in_buf, lsbhx_parser, lsbhx_out_buf
module lsb_stego_header_extractor import lsbhx_pkg::*; #(
  parameter int unsigned MAX_EXT_BYTES = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [7:0]             pixel_byte_i,
  input  logic                   first_byte_i,
  input  logic                   final_byte_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [1:0]             kind_o,
  output logic [7:0]             byte_value_o,
  output logic [2:0]             error_code_o,
  output logic [31:0]            payload_bits_o,
  output logic                   run_end_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [DIM_W-1:0]       cfg_data_i
);

  logic [DIM_W-1:0] width_q, height_q;
  item_t            in_item;
  item_t            main_item;
  logic             main_valid;
  logic             adv;
  logic             room;
  res_pair_t        res;
  result_t          head;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= '0;
      height_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        REG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input word register
  assign in_item.pixel_byte = pixel_byte_i;
  assign in_item.first_byte = first_byte_i;
  assign in_item.final_byte = final_byte_i;

  lsbhx_in_buf u_in_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_item_i    (in_item),
    .consume_i    (adv),
    .in_stall_o   (in_stall_o),
    .main_valid_o (main_valid),
    .main_item_o  (main_item)
  );

  // parse a word once its results have a place to go
  assign adv = main_valid & ((res.cnt == 2'd0) | room);

  lsbhx_parser #(
    .MAX_EXT_BYTES (MAX_EXT_BYTES)
  ) u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (adv),
    .item_i         (main_item),
    .image_width_i  (width_q),
    .image_height_i (height_q),
    .res_o          (res)
  );

  // result register
  lsbhx_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (adv & (res.cnt != 2'd0)),
    .res_i       (res),
    .out_stall_i (out_stall_i),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .head_o      (head)
  );

  assign kind_o         = head.kind;
  assign byte_value_o   = head.byte_value;
  assign error_code_o   = head.error_code;
  assign payload_bits_o = head.payload_bits;
  assign run_end_o      = head.run_end;

endmodule

// ===== src/lsbhx_in_buf.sv =====
// input register with a skid entry so the stall output is a flop
// depends on lsbhx_pkg for the input word type
module lsbhx_in_buf import lsbhx_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  item_t in_item_i,
  input  logic  consume_i,
  output logic  in_stall_o,
  output logic  main_valid_o,
  output item_t main_item_o
);

  logic  main_vld_q, main_vld_d;
  logic  skid_vld_q, skid_vld_d;
  item_t main_q, main_d;
  item_t skid_q, skid_d;
  logic  accept;
  logic  main_free;

  assign in_stall_o   = skid_vld_q;
  assign accept       = in_valid_i & ~skid_vld_q;
  assign main_free    = ~main_vld_q | consume_i;
  assign main_valid_o = main_vld_q;
  assign main_item_o  = main_q;

  // refill the main entry from the skid entry first, else from the port
  always_comb begin
    main_vld_d = main_vld_q;
    skid_vld_d = skid_vld_q;
    main_d     = main_q;
    skid_d     = skid_q;
    if (main_free) begin
      if (skid_vld_q) begin
        main_vld_d = 1'b1;
        main_d     = skid_q;
        skid_vld_d = 1'b0;
      end else begin
        main_vld_d = accept;
        main_d     = in_item_i;
      end
    end else if (accept) begin
      skid_vld_d = 1'b1;
      skid_d     = in_item_i;
    end
  end

  // control flops
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      main_vld_q <= main_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  // payload flops
  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule

// ===== src/lsbhx_parser.sv =====
// header and bit stream parser: parse state plus one-word update logic
// depends on lsbhx_pkg for word types, result kinds and error codes
module lsbhx_parser import lsbhx_pkg::*; #(
  parameter int unsigned MAX_EXT_BYTES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  item_t            item_i,
  input  logic [DIM_W-1:0] image_width_i,
  input  logic [DIM_W-1:0] image_height_i,
  output res_pair_t        res_o
);

  localparam int unsigned EXT_CNT_W = $clog2(MAX_EXT_BYTES + 1);
  localparam logic [EXT_CNT_W-1:0] EXT_LIMIT = EXT_CNT_W'(MAX_EXT_BYTES);

  // parse phases
  localparam logic [3:0] PH_IDLE   = 4'd0;
  localparam logic [3:0] PH_HEAD   = 4'd1;
  localparam logic [3:0] PH_SEP1   = 4'd2;
  localparam logic [3:0] PH_WIDTH  = 4'd3;
  localparam logic [3:0] PH_SEP2   = 4'd4;
  localparam logic [3:0] PH_HEIGHT = 4'd5;
  localparam logic [3:0] PH_SEP3   = 4'd6;
  localparam logic [3:0] PH_EXT    = 4'd7;
  localparam logic [3:0] PH_SIZE   = 4'd8;
  localparam logic [3:0] PH_SEP5   = 4'd9;
  localparam logic [3:0] PH_PAY    = 4'd10;

  logic [3:0]           phase_q, phase_d, cur_phase;
  logic [1:0]           idx_q, idx_d, cur_idx;
  logic [2:0]           count_q, count_d, cur_count;
  logic [1:0]           code_q, code_d, cur_code;
  logic [31:0]          shift_q, shift_d, cur_shift;
  logic [31:0]          ctr_q, ctr_d, cur_ctr;
  logic [31:0]          target_q, target_d, cur_target;
  logic [DIM_W-1:0]     hw_q, hw_d, cur_hw;
  logic [EXT_CNT_W-1:0] extcnt_q, extcnt_d, cur_extcnt;

  logic [7:0]  b;
  logic        first;
  logic [7:0]  bits;
  logic [2:0]  m;
  logic [5:0]  field_len;
  logic [4:0]  fc;
  logic [5:0]  need;
  logic        fld_full;
  logic [7:0]  used_bits;
  logic [31:0] fld_acc;
  logic [2:0]  rem;
  logic [7:0]  lbits;
  logic [2:0]  pp;
  logic [14:0] acc;
  logic [3:0]  rb;
  logic [31:0] togo;
  logic        pay_byte;
  logic        pay_done;

  logic        data_ev, term_ev;
  result_t     data_r, term_r;

  assign b     = item_i.pixel_byte;
  assign first = item_i.first_byte;

  // a first word restarts the parse from a clean state
  assign cur_phase  = first ? PH_HEAD : phase_q;
  assign cur_idx    = first ? 2'd0 : idx_q;
  assign cur_count  = first ? 3'd0 : count_q;
  assign cur_code   = first ? 2'd0 : code_q;
  assign cur_shift  = first ? 32'd0 : shift_q;
  assign cur_ctr    = first ? 32'd0 : ctr_q;
  assign cur_target = first ? 32'd0 : target_q;
  assign cur_hw     = first ? '0 : hw_q;
  assign cur_extcnt = first ? '0 : extcnt_q;

  // low bits carried by this word
  assign m    = cur_count;
  assign bits = b & ~(8'hff << m);

  // field phases: at most one field completes per word
  always_comb begin
    case (cur_phase)
      PH_WIDTH, PH_HEIGHT: field_len = 6'd11;
      PH_SIZE:             field_len = 6'd32;
      default:             field_len = 6'd8;
    endcase
  end

  assign fc        = cur_ctr[4:0];
  assign need      = field_len - {1'b0, fc};
  assign fld_full  = {3'b000, m} >= need;
  assign used_bits = fld_full ? (bits & ~(8'hff << need[2:0])) : bits;
  assign fld_acc   = cur_shift | (32'(used_bits) << fc);
  assign rem       = m - need[2:0];
  assign lbits     = bits >> need[2:0];

  // payload phase: byte boundary and end of payload
  assign pp       = cur_ctr[2:0];
  assign acc      = {7'd0, cur_shift[7:0]} | (15'(bits) << pp);
  assign rb       = 4'd8 - {1'b0, pp};
  assign togo     = cur_target - cur_ctr;
  assign pay_byte = ({1'b0, m} >= rb) && (32'(rb) <= togo);
  assign pay_done = togo <= 32'(m);

  // next state and the results of this word
  always_comb begin
    phase_d  = cur_phase;
    idx_d    = cur_idx;
    count_d  = cur_count;
    code_d   = cur_code;
    shift_d  = cur_shift;
    ctr_d    = cur_ctr;
    target_d = cur_target;
    hw_d     = cur_hw;
    extcnt_d = cur_extcnt;
    data_ev  = 1'b0;
    term_ev  = 1'b0;
    data_r   = '0;
    term_r   = '0;

    case (cur_phase)
      PH_IDLE: begin
        phase_d = PH_IDLE;
      end
      PH_HEAD: begin
        if (cur_idx == 2'd0) begin
          code_d = b[1:0];
        end else begin
          count_d = cur_count | (3'(b[0]) << (cur_idx - 2'd1));
        end
        if (cur_idx == 2'd3) begin
          if (cur_code != 2'd3 || count_d == 3'd0) begin
            term_ev           = 1'b1;
            term_r.kind       = KIND_ERR;
            term_r.error_code = ERR_HEADER;
            phase_d           = PH_IDLE;
          end else begin
            phase_d = PH_SEP1;
            shift_d = 32'd0;
            ctr_d   = 32'd0;
          end
        end else begin
          idx_d = cur_idx + 2'd1;
        end
      end
      PH_PAY: begin
        if (pay_byte) begin
          data_ev           = 1'b1;
          data_r.kind       = KIND_PAY;
          data_r.byte_value = acc[7:0];
        end
        if (pay_done) begin
          term_ev             = 1'b1;
          term_r.kind         = KIND_DONE;
          term_r.payload_bits = cur_target;
          phase_d             = PH_IDLE;
        end else begin
          ctr_d   = cur_ctr + 32'(m);
          shift_d = pay_byte ? 32'(acc[14:8]) : 32'(acc[7:0]);
        end
      end
      default: begin
        if (!fld_full) begin
          shift_d = fld_acc;
          ctr_d   = 32'(fc) + 32'(m);
        end else begin
          // leftover bits open the next field
          shift_d = 32'(lbits);
          ctr_d   = 32'(rem);
          case (cur_phase)
            PH_SEP1, PH_SEP2, PH_SEP3: begin
              if (fld_acc != 32'(SEP_CHAR)) begin
                term_ev           = 1'b1;
                term_r.kind       = KIND_ERR;
                term_r.error_code = ERR_SEPARATOR;
                phase_d           = PH_IDLE;
              end else begin
                phase_d = cur_phase + 4'd1;
              end
            end
            PH_WIDTH: begin
              hw_d    = fld_acc[DIM_W-1:0];
              phase_d = PH_SEP2;
            end
            PH_HEIGHT: begin
              if (cur_hw != image_width_i || fld_acc[DIM_W-1:0] != image_height_i) begin
                term_ev           = 1'b1;
                term_r.kind       = KIND_ERR;
                term_r.error_code = ERR_SIZE;
                phase_d           = PH_IDLE;
              end else begin
                phase_d = PH_SEP3;
              end
            end
            PH_EXT: begin
              if (fld_acc == 32'(NEWLINE_CHAR)) begin
                phase_d = PH_SIZE;
              end else if (cur_extcnt >= EXT_LIMIT) begin
                term_ev           = 1'b1;
                term_r.kind       = KIND_ERR;
                term_r.error_code = ERR_EXT_LONG;
                phase_d           = PH_IDLE;
              end else begin
                data_ev           = 1'b1;
                data_r.kind       = KIND_EXT;
                data_r.byte_value = fld_acc[7:0];
                extcnt_d          = cur_extcnt + EXT_CNT_W'(1);
              end
            end
            PH_SIZE: begin
              target_d = fld_acc;
              phase_d  = PH_SEP5;
            end
            PH_SEP5: begin
              if (fld_acc != 32'(SEP_CHAR)) begin
                term_ev           = 1'b1;
                term_r.kind       = KIND_ERR;
                term_r.error_code = ERR_SEPARATOR;
                phase_d           = PH_IDLE;
              end else if (cur_target == 32'd0) begin
                term_ev     = 1'b1;
                term_r.kind = KIND_DONE;
                phase_d     = PH_IDLE;
              end else if (cur_target <= 32'(rem)) begin
                // a short payload can end inside this very word
                term_ev             = 1'b1;
                term_r.kind         = KIND_DONE;
                term_r.payload_bits = cur_target;
                phase_d             = PH_IDLE;
              end else begin
                phase_d = PH_PAY;
              end
            end
            default: begin
              phase_d = PH_IDLE;
            end
          endcase
        end
      end
    endcase

    // image ended before the parse finished
    if (item_i.final_byte && phase_d != PH_IDLE) begin
      term_ev           = 1'b1;
      term_r            = '0;
      term_r.kind       = KIND_ERR;
      term_r.error_code = ERR_TRUNCATED;
      phase_d           = PH_IDLE;
    end
  end

  // pack the results in emission order
  always_comb begin
    res_o.cnt          = {1'b0, data_ev} + {1'b0, term_ev};
    res_o.head         = data_ev ? data_r : term_r;
    res_o.head.run_end = ~(data_ev & term_ev);
    res_o.tail         = term_r;
    res_o.tail.run_end = 1'b1;
  end

  // parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      idx_q    <= 2'd0;
      count_q  <= 3'd0;
      code_q   <= 2'd0;
      shift_q  <= 32'd0;
      ctr_q    <= 32'd0;
      target_q <= 32'd0;
      hw_q     <= '0;
      extcnt_q <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      idx_q    <= idx_d;
      count_q  <= count_d;
      code_q   <= code_d;
      shift_q  <= shift_d;
      ctr_q    <= ctr_d;
      target_q <= target_d;
      hw_q     <= hw_d;
      extcnt_q <= extcnt_d;
    end
  end

endmodule

// ===== src/lsbhx_out_buf.sv =====
// two-entry result buffer, a word out per unstalled cycle
// depends on lsbhx_pkg for the result types
module lsbhx_out_buf import lsbhx_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  res_pair_t res_i,
  input  logic      out_stall_i,
  output logic      room_o,
  output logic      out_valid_o,
  output result_t   head_o
);

  logic [1:0] cnt_q, cnt_d;
  result_t    head_q, head_d;
  result_t    tail_q, tail_d;
  logic       take;

  assign out_valid_o = cnt_q != 2'd0;
  assign take        = out_valid_o & ~out_stall_i;
  assign room_o      = (cnt_q == 2'd0) || (cnt_q == 2'd1 && take);
  assign head_o      = head_q;

  // load a new pair or advance the tail to the head
  always_comb begin
    cnt_d  = cnt_q;
    head_d = head_q;
    tail_d = tail_q;
    if (load_i) begin
      cnt_d  = res_i.cnt;
      head_d = res_i.head;
      tail_d = res_i.tail;
    end else if (take) begin
      cnt_d = cnt_q - 2'd1;
      if (cnt_q == 2'd2) begin
        head_d = tail_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

endmodule

// ===== sim/lsb_stego_header_extractor_tb.sv =====
// self-checking testbench for lsb_stego_header_extractor: a directed table, then random carrier images
// result words must match a bit-level extraction predictor kept in step with the input or a table row
// depends on lsbhx_pkg and the lsb_stego_header_extractor rtl
`timescale 1ns / 1ps

module lsb_stego_header_extractor_tb import lsbhx_pkg::*;;

  localparam int unsigned MAX_EXT      = 16;
  localparam int unsigned RAND_WORDS   = 1600;
  localparam int unsigned SETTLE       = 8;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned PRINT_LIMIT  = 50;
  localparam int          DIR_ROWS     = 24;

  // parse phases of the predictor
  typedef enum logic [3:0] {
    ST_IDLE, ST_HEAD, ST_SEP1, ST_WIDTH, ST_SEP2, ST_HEIGHT, ST_SEP3,
    ST_EXT, ST_SIZE, ST_SEP5, ST_PAY
  } parse_st_e;

  // how a stimulus word is checked
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} row_check_e;

  // shapes of random images
  typedef enum logic [2:0] {
    IMG_GOOD, IMG_BAD_HEAD, IMG_BAD_SEP, IMG_BAD_DIM, IMG_LONG_EXT, IMG_TRUNC, IMG_RESTART
  } img_mode_e;

  typedef struct packed {
    logic [7:0] pix;
    logic       first;
    logic       last;
    row_check_e chk;
    logic [1:0] kind;
    logic [2:0] err;
  } stim_row_t;

  logic                   clk_i          = 1'b0;
  logic                   rst_ni         = 1'b0;
  logic                   in_valid_i     = 1'b0;
  logic                   in_stall_o;
  logic [7:0]             pixel_byte_i   = '0;
  logic                   first_byte_i   = 1'b0;
  logic                   final_byte_i   = 1'b0;
  logic                   out_valid_o;
  logic                   out_stall_i    = 1'b0;
  logic [1:0]             kind_o;
  logic [7:0]             byte_value_o;
  logic [2:0]             error_code_o;
  logic [31:0]            payload_bits_o;
  logic                   run_end_o;
  logic                   cfg_valid_i    = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_INDEX_W-1:0] cfg_index_i    = '0;
  logic [DIM_W-1:0]       cfg_data_i     = '0;

  lsb_stego_header_extractor #(
    .MAX_EXT_BYTES(MAX_EXT)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pixel_byte_i  (pixel_byte_i),
    .first_byte_i  (first_byte_i),
    .final_byte_i  (final_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .byte_value_o  (byte_value_o),
    .error_code_o  (error_code_o),
    .payload_bits_o(payload_bits_o),
    .run_end_o     (run_end_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // clock
  always #10 clk_i = ~clk_i;

  // predictor state and its copy of the size registers
  parse_st_e   m_phase  = ST_IDLE;
  logic [2:0]  m_nbits  = '0;
  logic [1:0]  m_code   = '0;
  logic [31:0] m_shift  = '0;
  logic [31:0] m_count  = '0;
  logic [31:0] m_target = '0;
  logic [10:0] m_width  = '0;
  logic [7:0]  m_ext    = '0;
  logic [1:0]  m_idx    = '0;
  logic [10:0] cfg_w    = '0;
  logic [10:0] cfg_h    = '0;
  logic        word_ignored;

  result_t     step_res[$];
  result_t     result_q[$];
  bit          stream_q[$];

  int unsigned send_gap_pct   = 18;
  int unsigned recv_stall_pct = 70;
  int unsigned live_words     = 0;
  int unsigned mismatch_cnt   = 0;
  int unsigned cycle_cnt      = 0;

  // directed table, walked in order after reset with both size registers at zero
  stim_row_t dir_tab [DIR_ROWS] = '{
    '{8'h5A, 1'b0, 1'b0, CHK_NONE,  KIND_EXT, ERR_NONE},      // idle, no first flag
    '{8'hFC, 1'b1, 1'b0, CHK_MODEL, KIND_EXT, ERR_NONE},      // code 0
    '{8'h01, 1'b0, 1'b0, CHK_MODEL, KIND_EXT, ERR_NONE},
    '{8'h01, 1'b0, 1'b0, CHK_MODEL, KIND_EXT, ERR_NONE},
    '{8'h01, 1'b0, 1'b0, CHK_ONE,   KIND_ERR, ERR_HEADER},
    '{8'hFF, 1'b1, 1'b0, CHK_MODEL, KIND_EXT, ERR_NONE},      // code 3, count 0
    '{8'hFE, 1'b0, 1'b0, CHK_MODEL, KIND_EXT, ERR_NONE},
    '{8'hFE, 1'b0, 1'b0, CHK_MODEL, KIND_EXT, ERR_NONE},
    '{8'h00, 1'b0, 1'b0, CHK_ONE,   KIND_ERR, ERR_HEADER},
    '{8'h80, 1'b0, 1'b1, CHK_NONE,  KIND_EXT, ERR_NONE},      // last flag while idle
    '{8'h03, 1'b1, 1'b1, CHK_ONE,   KIND_ERR, ERR_TRUNCATED}, // first and last together
    '{8'h03, 1'b1, 1'b0, CHK_MODEL, KIND_EXT, ERR_NONE},      // good header, count 7
    '{8'h01, 1'b0, 1'b0, CHK_MODEL, KIND_EXT, ERR_NONE},
    '{8'h01, 1'b0, 1'b0, CHK_MODEL, KIND_EXT, ERR_NONE},
    '{8'h01, 1'b0, 1'b0, CHK_MODEL, KIND_EXT, ERR_NONE},
    '{8'hF8, 1'b0, 1'b0, CHK_MODEL, KIND_EXT, ERR_NONE},      // low seven bits of the separator
    '{8'h7E, 1'b0, 1'b0, CHK_MODEL, KIND_EXT, ERR_NONE},      // separator done, width starts
    '{8'h03, 1'b1, 1'b0, CHK_MODEL, KIND_EXT, ERR_NONE},      // restart mid-image
    '{8'h01, 1'b0, 1'b0, CHK_MODEL, KIND_EXT, ERR_NONE},
    '{8'h01, 1'b0, 1'b0, CHK_MODEL, KIND_EXT, ERR_NONE},
    '{8'h01, 1'b0, 1'b0, CHK_MODEL, KIND_EXT, ERR_NONE},
    '{8'h00, 1'b0, 1'b0, CHK_MODEL, KIND_EXT, ERR_NONE},
    '{8'h7F, 1'b0, 1'b0, CHK_ONE,   KIND_ERR, ERR_SEPARATOR}, // separator reads 0x80
    '{8'h55, 1'b0, 1'b0, CHK_NONE,  KIND_EXT, ERR_NONE}       // idle after the error
  };

  // predictor: append one result word for the current input word
  function automatic void add_result(input logic [1:0] kind, input logic [7:0] val,
                                     input logic [2:0] err, input logic [31:0] bits);
    result_t r;
    r.kind         = kind;
    r.byte_value   = val;
    r.error_code   = err;
    r.payload_bits = bits;
    r.run_end      = 1'b0;
    step_res.insert(step_res.size(), r);
  endfunction

  function automatic void abort_parse(input logic [2:0] err);
    add_result(KIND_ERR, '0, err, '0);
    m_phase = ST_IDLE;
  endfunction

  // predictor: one bit of the hidden stream
  function automatic void take_bit(input logic b);
    logic [31:0] val;
    int unsigned flen;
    if (m_phase == ST_PAY) begin
      m_shift = m_shift | (32'(b) << m_count[2:0]);
      m_count = m_count + 1;
      if (m_count[2:0] == 3'd0) begin
        add_result(KIND_PAY, m_shift[7:0], ERR_NONE, '0);
        m_shift = '0;
      end
      if (m_count == m_target) begin
        add_result(KIND_DONE, '0, ERR_NONE, m_target);
        m_phase = ST_IDLE;
      end
    end else begin
      m_shift = m_shift | (32'(b) << m_count[4:0]);
      m_count = m_count + 1;
      if (m_phase == ST_WIDTH || m_phase == ST_HEIGHT) flen = DIM_W;
      else if (m_phase == ST_SIZE) flen = 32;
      else flen = 8;
      if (m_count >= flen) begin
        val     = m_shift;
        m_shift = '0;
        m_count = '0;
        case (m_phase)
          ST_SEP1: if (val != SEP_CHAR) abort_parse(ERR_SEPARATOR); else m_phase = ST_WIDTH;
          ST_SEP2: if (val != SEP_CHAR) abort_parse(ERR_SEPARATOR); else m_phase = ST_HEIGHT;
          ST_SEP3: if (val != SEP_CHAR) abort_parse(ERR_SEPARATOR); else m_phase = ST_EXT;
          ST_WIDTH: begin
            m_width = val[10:0];
            m_phase = ST_SEP2;
          end
          ST_HEIGHT: begin
            if (m_width != cfg_w || val[10:0] != cfg_h) abort_parse(ERR_SIZE);
            else m_phase = ST_SEP3;
          end
          ST_EXT: begin
            if (val == NEWLINE_CHAR) begin
              m_phase = ST_SIZE;
            end else if (m_ext >= MAX_EXT) begin
              abort_parse(ERR_EXT_LONG);
            end else begin
              add_result(KIND_EXT, val[7:0], ERR_NONE, '0);
              m_ext = m_ext + 8'd1;
            end
          end
          ST_SIZE: begin
            m_target = val;
            m_phase  = ST_SEP5;
          end
          ST_SEP5: begin
            if (val != SEP_CHAR) begin
              abort_parse(ERR_SEPARATOR);
            end else if (m_target == 0) begin
              add_result(KIND_DONE, '0, ERR_NONE, '0);
              m_phase = ST_IDLE;
            end else begin
              m_phase = ST_PAY;
            end
          end
          default: m_phase = ST_IDLE;
        endcase
      end
    end
  endfunction

  // predictor: one accepted input word, results left in step_res
  function automatic void predict_word(input logic [7:0] pix, input logic first,
                                       input logic last);
    step_res.delete();
    word_ignored = 1'b0;
    if (first) begin
      m_phase  = ST_HEAD;
      m_nbits  = '0;
      m_code   = '0;
      m_shift  = '0;
      m_count  = '0;
      m_target = '0;
      m_width  = '0;
      m_ext    = '0;
      m_idx    = '0;
    end
    if (m_phase == ST_IDLE) begin
      word_ignored = 1'b1;
      return;
    end
    if (m_phase == ST_HEAD) begin
      if (m_idx == 2'd0) m_code = pix[1:0];
      else m_nbits = m_nbits | (3'(pix[0]) << (m_idx - 2'd1));
      if (m_idx == 2'd3) begin
        if (m_code != 2'd3 || m_nbits == 3'd0) begin
          abort_parse(ERR_HEADER);
        end else begin
          m_phase = ST_SEP1;
          m_shift = '0;
          m_count = '0;
        end
      end else begin
        m_idx = m_idx + 2'd1;
      end
    end else begin
      for (int unsigned k = 0; k < m_nbits && m_phase != ST_IDLE; k++) take_bit(pix[k]);
    end
    if (last && m_phase != ST_IDLE) abort_parse(ERR_TRUNCATED);
    if (step_res.size() > 0) begin
      step_res[step_res.size() - 1].run_end = 1'b1;
    end
  endfunction

  // offer one input word, wait for the handshake, then record what it should cause
  task automatic send_word(input logic [7:0] pix, input logic first, input logic last,
                           input row_check_e chk, input logic [1:0] kind,
                           input logic [2:0] err);
    result_t r;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    pixel_byte_i <= pix;
    first_byte_i <= first;
    final_byte_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_word(pix, first, last);
    if (!word_ignored) live_words++;
    case (chk)
      CHK_MODEL: foreach (step_res[i]) result_q.insert(result_q.size(), step_res[i]);
      CHK_ONE: begin
        r            = '0;
        r.kind       = kind;
        r.error_code = err;
        r.run_end    = 1'b1;
        result_q.insert(result_q.size(), r);
      end
      default: ;
    endcase
  endtask

  // stop sending, let every expected word come out and the pipe settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // write both size registers back to back
  task automatic set_image_size(input logic [10:0] w, input logic [10:0] h);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_IMAGE_WIDTH;
    cfg_data_i  <= w;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_w = w;
    cfg_index_i <= REG_IMAGE_HEIGHT;
    cfg_data_i  <= h;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_h = h;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic void push_bits(input logic [31:0] v, input int unsigned n);
    for (int unsigned i = 0; i < n; i++) stream_q.insert(stream_q.size(), v[i]);
  endfunction

  // one random carrier image, well formed or broken on purpose
  task automatic send_image();
    img_mode_e   mode;
    int unsigned pick, n_ext, n_pay, n_stream, n_total, cut, idx;
    logic [2:0]  cnt;
    logic [1:0]  code;
    logic [10:0] w, h;
    logic [31:0] pay_size;
    logic [7:0]  seps [4];
    logic [7:0]  b, e;
    logic        has_final, huge;
    pick = $urandom_range(99);
    if (pick < 60) mode = IMG_GOOD;
    else if (pick < 65) mode = IMG_BAD_HEAD;
    else if (pick < 70) mode = IMG_BAD_SEP;
    else if (pick < 75) mode = IMG_BAD_DIM;
    else if (pick < 80) mode = IMG_LONG_EXT;
    else if (pick < 90) mode = IMG_TRUNC;
    else mode = IMG_RESTART;

    cnt  = 3'($urandom_range(1, 7));
    code = 2'd3;
    w    = cfg_w;
    h    = cfg_h;
    for (int i = 0; i < 4; i++) seps[i] = SEP_CHAR;
    n_ext    = ($urandom_range(3) == 0) ? $urandom_range(0, MAX_EXT) : $urandom_range(0, 3);
    pay_size = ($urandom_range(7) == 0) ? 32'd0 : 32'($urandom_range(1, 72));
    n_pay    = pay_size;
    huge     = 1'b0;

    // break the image where the mode asks
    case (mode)
      IMG_BAD_HEAD: begin
        if ($urandom_range(1) == 1) code = 2'($urandom_range(0, 2));
        else cnt = 3'd0;
      end
      IMG_BAD_SEP: seps[$urandom_range(3)] ^= 8'($urandom_range(1, 255));
      IMG_BAD_DIM: begin
        if ($urandom_range(1) == 1) w ^= 11'($urandom_range(1, 2047));
        else h ^= 11'($urandom_range(1, 2047));
      end
      IMG_LONG_EXT: n_ext = MAX_EXT + 1 + $urandom_range(1);
      IMG_TRUNC: begin
        if ($urandom_range(1) == 1) begin
          huge     = 1'b1;
          pay_size = $urandom | 32'h80;
          n_pay    = $urandom_range(0, 40);
        end
      end
      default: ;
    endcase

    // hidden bit stream
    stream_q.delete();
    push_bits(32'(seps[0]), 8);
    push_bits(32'(w), DIM_W);
    push_bits(32'(seps[1]), 8);
    push_bits(32'(h), DIM_W);
    push_bits(32'(seps[2]), 8);
    for (int unsigned i = 0; i < n_ext; i++) begin
      e = 8'($urandom);
      if (e == NEWLINE_CHAR) e = 8'h00;
      push_bits(32'(e), 8);
    end
    push_bits(32'(NEWLINE_CHAR), 8);
    push_bits(pay_size, 32);
    push_bits(32'(seps[3]), 8);
    for (int unsigned i = 0; i < n_pay; i++) stream_q.insert(stream_q.size(), 1'($urandom));

    if (mode == IMG_BAD_HEAD) begin
      n_stream = $urandom_range(0, 2);
    end else begin
      n_stream = (stream_q.size() + cnt - 1) / cnt;
      if (mode == IMG_GOOD && $urandom_range(3) == 0) n_stream += $urandom_range(1, 2);
    end
    n_total = 4 + n_stream;

    // where the image stops and whether it is marked as ended
    case (mode)
      IMG_TRUNC: begin
        has_final = 1'b1;
        cut       = huge ? n_total : $urandom_range(1, n_total);
      end
      IMG_RESTART: begin
        has_final = 1'b0;
        cut       = $urandom_range(1, n_total - 1);
      end
      default: begin
        has_final = 1'($urandom_range(1));
        cut       = n_total;
      end
    endcase

    // header words, then stream words with random upper bits
    for (int unsigned j = 0; j < cut; j++) begin
      b = 8'($urandom);
      if (j == 0) begin
        b[1:0] = code;
      end else if (j < 4) begin
        b[0] = cnt[j-1];
      end else begin
        for (int unsigned k = 0; k < cnt; k++) begin
          idx = (j - 4) * cnt + k;
          if (idx < stream_q.size()) b[k] = stream_q[idx];
        end
      end
      send_word(b, j == 0, has_final && (j == cut - 1), CHK_MODEL, KIND_EXT, ERR_NONE);
    end
  endtask

  // receiver stalls at random
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic report_mismatch(input string what);
    mismatch_cnt++;
    if (mismatch_cnt <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // result checker
  always @(posedge clk_i) begin : out_check
    result_t got;
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.kind         = kind_o;
      got.byte_value   = byte_value_o;
      got.error_code   = error_code_o;
      got.payload_bits = payload_bits_o;
      got.run_end      = run_end_o;
      if (result_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word kind %0d byte %02h err %0d bits %08h end %0d",
                                  got.kind, got.byte_value, got.error_code,
                                  got.payload_bits, got.run_end));
      end else begin
        want = result_q.pop_front();
        if (got.kind !== want.kind || got.byte_value !== want.byte_value ||
            got.error_code !== want.error_code || got.payload_bits !== want.payload_bits ||
            got.run_end !== want.run_end) begin
          report_mismatch($sformatf(
            "got kind %0d byte %02h err %0d bits %08h end %0d, want %0d %02h %0d %08h %0d",
            got.kind, got.byte_value, got.error_code, got.payload_bits, got.run_end,
            want.kind, want.byte_value, want.error_code, want.payload_bits, want.run_end));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // main sequence
  initial begin : stim
    int unsigned n_img, cfg_round;
    n_img     = 0;
    cfg_round = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_word(dir_tab[i].pix, dir_tab[i].first, dir_tab[i].last, dir_tab[i].chk,
                dir_tab[i].kind, dir_tab[i].err);
    end

    // random images, size registers changed every few images
    live_words = 0;
    while (live_words < RAND_WORDS) begin
      if (n_img % 6 == 0) begin
        wait_idle();
        case (cfg_round % 6)
          1: set_image_size(11'd2047, 11'd2047);
          2: set_image_size(11'd0, 11'd0);
          3: set_image_size(11'd0, 11'd2047);
          4: set_image_size(11'd2047, 11'd0);
          default: set_image_size(11'($urandom), 11'($urandom));
        endcase
        cfg_round++;
      end
      if (live_words < RAND_WORDS / 3) begin
        send_gap_pct   = 18;
        recv_stall_pct = 70;
      end else if (live_words < 2 * RAND_WORDS / 3) begin
        send_gap_pct   = 70;
        recv_stall_pct = 18;
      end else begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      send_image();
      // stray words between images
      if (m_phase == ST_IDLE && $urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 3))
          send_word(8'($urandom), 1'b0, 1'($urandom_range(1)), CHK_MODEL, KIND_EXT, ERR_NONE);
      end
      n_img++;
    end

    wait_idle();
    if (mismatch_cnt == 0 && result_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
